FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/ldm_pkg.sv
package ldm_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int RING_DEPTH_DEF  = 8;
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int HANDLE_BASE_DEF = 3;

    // widest slot index for the largest table
    localparam int IDX_W = 6;

    localparam logic [2:0] CMD_OPEN  = 3'd0;
    localparam logic [2:0] CMD_BIND  = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RECV  = 3'd3;
    localparam logic [2:0] CMD_CLOSE = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;
    localparam logic [2:0] CMD_CLEAR = 3'd6;

    localparam logic [1:0] CFG_DOMAIN   = 2'd0;
    localparam logic [1:0] CFG_KIND     = 2'd1;
    localparam logic [1:0] CFG_PROTOCOL = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_SEND_CHECK,
        ST_SEND_BYTE,
        ST_RX_META,
        ST_RX_LEN,
        ST_RX_READ,
        ST_RX_EMIT,
        ST_RESULT
    } t_state;

    typedef enum logic {
        SRCH_FREE,
        SRCH_PORT
    } t_srch_mode;

    typedef struct packed {
        logic       start;
        t_srch_mode mode;
        logic [15:0] key;
    } t_srch_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_srch_rsp;

    typedef struct packed {
        logic        used;
        logic        bound;
        logic [15:0] port;
    } t_slot_view;

endpackage

FILE: src/ldm_slot_search.sv
`include "assert_macros.svh"

module ldm_slot_search #(
    parameter int SLOT_COUNT = ldm_pkg::SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ldm_pkg::t_srch_req  i_req,
    input  ldm_pkg::t_slot_view i_view,
    output ldm_pkg::t_srch_rsp  o_rsp
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

    logic                r_busy;
    logic [SW-1:0]       r_idx;
    ldm_pkg::t_srch_mode r_mode;
    logic [15:0]         r_key;
    logic                w_match;
    logic                w_end;

    // one slot compared per cycle
    assign w_match = (r_mode == ldm_pkg::SRCH_FREE) ? !i_view.used :
                     (i_view.used && i_view.bound && (i_view.port == r_key));
    assign w_end   = w_match || (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_end) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_idx  <= '0;
            r_mode <= i_req.mode;
            r_key  <= i_req.key;
        end else if (r_busy && !w_end) begin
            r_idx <= r_idx + SW'(1);
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_busy && w_end;
    assign o_rsp.found = r_busy && w_match;
    assign o_rsp.idx   = ldm_pkg::IDX_W'(r_idx);

    `ASSERT_CLK(a_idx_range, i_clk, i_rst_n, r_busy |-> (r_idx <= LAST_IDX), "scan index past table")
    `ASSERT_NEVER(a_no_restart, i_clk, i_rst_n, i_req.start && r_busy, "scan restarted while busy")

endmodule

FILE: src/loopback_datagram_mailbox_core.sv
// close, read, clear counters and decode errors go from decode straight to the result word
// open and bind add a slot scan; a first send word adds a scan for the port and a ring check
// a send word stores its byte and frees the input, going to the result word on the final byte
// receive reads metadata, then reads and emits each payload word; empty copies emit a result word
// one item at a time, set by the shared slot scan and the single payload port
// reset is synchronous active low: slot table, rings, counters, state clear, memories do not

`include "assert_macros.svh"

module loopback_datagram_mailbox_core #(
    parameter int SLOT_COUNT  = ldm_pkg::SLOT_COUNT_DEF,
    parameter int RING_DEPTH  = ldm_pkg::RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = ldm_pkg::MAX_PAYLOAD_DEF,
    parameter int HANDLE_BASE = ldm_pkg::HANDLE_BASE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // handle, port, length, data_byte, domain_code, kind_code, protocol_code
    input  logic [63:0]  s_axis_tdata,
    // command
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, value, out_byte, source_port, sent_total, received_total, dropped_total
    output logic [135:0] m_axis_tdata,
    // byte_valid
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int EW = SW + RW;
    localparam int AW = EW + PW;
    localparam int PAY_DEPTH  = 1 << AW;
    localparam int META_DEPTH = 1 << EW;
    localparam logic [8:0]    HB9       = 9'(HANDLE_BASE);
    localparam logic [8:0]    SC9       = 9'(SLOT_COUNT);
    localparam logic [6:0]    MAXP7     = 7'(MAX_PAYLOAD);
    localparam logic [CW-1:0] RD_C      = CW'(RING_DEPTH);
    localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);

    ldm_pkg::t_state r_state;
    ldm_pkg::t_state n_state;

    // latched item
    logic [2:0]  r_cmd;
    logic [7:0]  r_handle;
    logic [15:0] r_port;
    logic [6:0]  r_len;
    logic [7:0]  r_byte;
    logic [7:0]  r_dom;
    logic [7:0]  r_kind;
    logic [7:0]  r_prot;

    logic [7:0] r_acc_dom;
    logic [7:0] r_acc_kind;
    logic [7:0] r_acc_prot;

    // slot table
    logic          r_used  [SLOT_COUNT];
    logic          r_bound [SLOT_COUNT];
    logic [15:0]   r_sport [SLOT_COUNT];
    logic [RW-1:0] r_head  [SLOT_COUNT];
    logic [RW-1:0] r_tail  [SLOT_COUNT];
    logic [CW-1:0] r_count [SLOT_COUNT];

    logic [31:0] r_sent;
    logic [31:0] r_recv;
    logic [31:0] r_drop;

    // send in progress
    logic          r_active;
    logic [SW-1:0] r_dst;
    logic [6:0]    r_slen;
    logic [6:0]    r_done;
    logic [15:0]   r_src;

    // receive
    logic [EW-1:0] r_ent;
    logic [6:0]    r_cap;
    logic [6:0]    r_n;
    logic [6:0]    r_i;

    logic [7:0]  r_pay_mem  [PAY_DEPTH];
    logic [22:0] r_meta_mem [META_DEPTH];
    logic [7:0]  r_pay_rd;
    logic [22:0] r_meta_rd;

    logic        r_res_status;
    logic [7:0]  r_res_value;
    logic [15:0] r_res_src;
    logic        r_res_cnt;

    logic        r_ovalid;
    logic        r_o_status;
    logic [7:0]  r_o_value;
    logic [7:0]  r_o_byte;
    logic        r_o_bv;
    logic [15:0] r_o_src;
    logic        r_o_last;
    logic [31:0] r_o_sent;
    logic [31:0] r_o_recv;
    logic [31:0] r_o_drop;

    ldm_pkg::t_srch_req  w_srch_req;
    ldm_pkg::t_srch_rsp  w_srch_rsp;
    ldm_pkg::t_slot_view w_view;

    logic [8:0]    w_hoff;
    logic          w_hrange;
    logic [SW-1:0] w_hslot;
    logic [SW-1:0] w_rd_idx;
    logic [SW-1:0] w_fidx;
    logic [RW-1:0] w_vhead;
    logic [RW-1:0] w_vtail;
    logic [CW-1:0] w_vcount;
    logic [RW-1:0] w_head_inc;
    logic [RW-1:0] w_tail_inc;
    logic          w_hok;
    logic          w_codes_ok;
    logic          w_len_ok;
    logic          w_dec_fail;
    logic          w_dec_srch;
    logic          w_full;
    logic          w_commit;
    logic [6:0]    w_meta_len;
    logic [15:0]   w_meta_src;
    logic [6:0]    w_n;
    logic          w_rx_last;
    logic          w_ofree;
    logic          w_accept;
    logic          w_res_status;
    logic [7:0]    w_res_value;
    logic [15:0]   w_res_src;
    logic          w_res_cnt;
    logic          w_ld_result;
    logic          w_ld_byte;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_ofree  = !r_ovalid || m_axis_tready;

    // handle resolve
    assign w_hoff   = {1'b0, r_handle} - HB9;
    assign w_hrange = ({1'b0, r_handle} >= HB9) && (w_hoff < SC9);
    assign w_hslot  = w_hoff[SW-1:0];
    assign w_fidx   = w_srch_rsp.idx[SW-1:0];

    // one table read address per cycle
    always_comb begin
        case (r_state)
            ldm_pkg::ST_SEARCH:     w_rd_idx = w_fidx;
            ldm_pkg::ST_SEND_CHECK: w_rd_idx = r_dst;
            ldm_pkg::ST_SEND_BYTE:  w_rd_idx = r_dst;
            default:                w_rd_idx = w_hslot;
        endcase
    end

    assign w_view.used  = r_used[w_rd_idx];
    assign w_view.bound = r_bound[w_rd_idx];
    assign w_view.port  = r_sport[w_rd_idx];
    assign w_vhead      = r_head[w_rd_idx];
    assign w_vtail      = r_tail[w_rd_idx];
    assign w_vcount     = r_count[w_rd_idx];
    assign w_head_inc   = (w_vhead == RING_LAST) ? '0 : RW'(w_vhead + RW'(1));
    assign w_tail_inc   = (w_vtail == RING_LAST) ? '0 : RW'(w_vtail + RW'(1));

    assign w_hok      = w_hrange && w_view.used;
    assign w_codes_ok = (r_dom == r_acc_dom) && (r_kind == r_acc_kind) &&
                        (r_prot == r_acc_prot);
    assign w_len_ok   = (r_len != 7'd0) && (r_len <= MAXP7);
    assign w_full     = (w_vcount >= RD_C);
    assign w_commit   = (7'(r_done + 7'd1) == r_slen);
    assign w_meta_len = r_meta_rd[6:0];
    assign w_meta_src = r_meta_rd[22:7];
    assign w_n        = (w_meta_len < r_cap) ? w_meta_len : r_cap;
    assign w_rx_last  = (7'(r_i + 7'd1) == r_n);

    always_comb begin
        w_dec_fail = 1'b0;
        w_dec_srch = 1'b0;
        case (r_cmd)
            ldm_pkg::CMD_OPEN: begin
                w_dec_fail = !w_codes_ok;
                w_dec_srch = w_codes_ok;
            end
            ldm_pkg::CMD_BIND: begin
                w_dec_fail = (r_port == 16'd0) || !w_hok || w_view.bound;
                w_dec_srch = !w_dec_fail;
            end
            ldm_pkg::CMD_SEND: begin
                w_dec_fail = !r_active && (!w_hok || !w_len_ok || (r_port == 16'd0));
                w_dec_srch = !r_active && !w_dec_fail;
            end
            ldm_pkg::CMD_RECV:  w_dec_fail = !w_hok || (w_vcount == '0);
            ldm_pkg::CMD_CLOSE: w_dec_fail = !w_hok;
            ldm_pkg::CMD_READ:  w_dec_fail = 1'b0;
            ldm_pkg::CMD_CLEAR: w_dec_fail = 1'b0;
            default:            w_dec_fail = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ldm_pkg::ST_IDLE: begin
                if (w_accept) n_state = ldm_pkg::ST_DECODE;
            end
            ldm_pkg::ST_DECODE: begin
                if (w_dec_fail) begin
                    n_state = ldm_pkg::ST_RESULT;
                end else if (w_dec_srch) begin
                    n_state = ldm_pkg::ST_SEARCH;
                end else if (r_cmd == ldm_pkg::CMD_SEND) begin
                    n_state = ldm_pkg::ST_SEND_BYTE;
                end else if (r_cmd == ldm_pkg::CMD_RECV) begin
                    n_state = ldm_pkg::ST_RX_META;
                end else begin
                    n_state = ldm_pkg::ST_RESULT;
                end
            end
            ldm_pkg::ST_SEARCH: begin
                if (w_srch_rsp.done) begin
                    if ((r_cmd == ldm_pkg::CMD_SEND) && w_srch_rsp.found) begin
                        n_state = ldm_pkg::ST_SEND_CHECK;
                    end else begin
                        n_state = ldm_pkg::ST_RESULT;
                    end
                end
            end
            ldm_pkg::ST_SEND_CHECK: begin
                n_state = w_full ? ldm_pkg::ST_RESULT : ldm_pkg::ST_SEND_BYTE;
            end
            ldm_pkg::ST_SEND_BYTE: begin
                n_state = w_commit ? ldm_pkg::ST_RESULT : ldm_pkg::ST_IDLE;
            end
            ldm_pkg::ST_RX_META: n_state = ldm_pkg::ST_RX_LEN;
            ldm_pkg::ST_RX_LEN: begin
                n_state = (w_n == 7'd0) ? ldm_pkg::ST_RESULT : ldm_pkg::ST_RX_READ;
            end
            ldm_pkg::ST_RX_READ: n_state = ldm_pkg::ST_RX_EMIT;
            ldm_pkg::ST_RX_EMIT: begin
                if (w_ofree) n_state = w_rx_last ? ldm_pkg::ST_IDLE : ldm_pkg::ST_RX_READ;
            end
            ldm_pkg::ST_RESULT: begin
                if (w_ofree) n_state = ldm_pkg::ST_IDLE;
            end
            default: n_state = ldm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_srch_req.start = (r_state == ldm_pkg::ST_DECODE) && w_dec_srch;
        w_srch_req.mode  = (r_cmd == ldm_pkg::CMD_OPEN) ? ldm_pkg::SRCH_FREE :
                                                           ldm_pkg::SRCH_PORT;
        w_srch_req.key   = r_port;
        w_ld_result      = (r_state == ldm_pkg::ST_RESULT) && w_ofree;
        w_ld_byte        = (r_state == ldm_pkg::ST_RX_EMIT) && w_ofree;
        w_res_status     = 1'b1;
        w_res_value      = 8'd0;
        w_res_src        = 16'd0;
        w_res_cnt        = 1'b0;
        case (r_state)
            ldm_pkg::ST_DECODE: begin
                if (!w_dec_fail) begin
                    w_res_status = 1'b0;
                    w_res_cnt    = (r_cmd == ldm_pkg::CMD_READ) ||
                                   (r_cmd == ldm_pkg::CMD_CLEAR);
                end
            end
            ldm_pkg::ST_SEARCH: begin
                if (r_cmd == ldm_pkg::CMD_OPEN) begin
                    w_res_status = !w_srch_rsp.found;
                    w_res_value  = w_srch_rsp.found ? 8'(HB9 + 9'(w_fidx)) : 8'd0;
                end else if (r_cmd == ldm_pkg::CMD_BIND) begin
                    w_res_status = w_srch_rsp.found;
                end
            end
            ldm_pkg::ST_SEND_BYTE: begin
                w_res_status = 1'b0;
                w_res_value  = {1'b0, r_slen};
            end
            ldm_pkg::ST_RX_LEN: begin
                w_res_status = 1'b0;
                w_res_src    = w_meta_src;
            end
            default: w_res_status = 1'b1;
        endcase
    end

    ldm_slot_search #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_search (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_srch_req),
        .i_view (w_view),
        .o_rsp  (w_srch_rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ldm_pkg::ST_IDLE;
            r_acc_dom  <= 8'd0;
            r_acc_kind <= 8'd0;
            r_acc_prot <= 8'd0;
            r_sent     <= 32'd0;
            r_recv     <= 32'd0;
            r_drop     <= 32'd0;
            r_active   <= 1'b0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_used[i]  <= 1'b0;
                r_bound[i] <= 1'b0;
                r_sport[i] <= 16'd0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ldm_pkg::CFG_DOMAIN:   r_acc_dom  <= i_cfg_data;
                    ldm_pkg::CFG_KIND:     r_acc_kind <= i_cfg_data;
                    ldm_pkg::CFG_PROTOCOL: r_acc_prot <= i_cfg_data;
                    default:               r_acc_dom  <= r_acc_dom;
                endcase
            end
            if (w_ld_result || w_ld_byte) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ldm_pkg::ST_DECODE: begin
                    if (r_cmd != ldm_pkg::CMD_SEND) r_active <= 1'b0;
                    if ((r_cmd == ldm_pkg::CMD_RECV) && !w_dec_fail) begin
                        r_tail[w_hslot]  <= w_tail_inc;
                        r_count[w_hslot] <= w_vcount - CW'(1);
                        r_recv           <= r_recv + 32'd1;
                    end
                    if ((r_cmd == ldm_pkg::CMD_CLOSE) && !w_dec_fail) begin
                        r_used[w_hslot]  <= 1'b0;
                        r_bound[w_hslot] <= 1'b0;
                        r_sport[w_hslot] <= 16'd0;
                        r_head[w_hslot]  <= '0;
                        r_tail[w_hslot]  <= '0;
                        r_count[w_hslot] <= '0;
                    end
                    if (r_cmd == ldm_pkg::CMD_CLEAR) begin
                        r_sent <= 32'd0;
                        r_recv <= 32'd0;
                        r_drop <= 32'd0;
                    end
                end
                ldm_pkg::ST_SEARCH: begin
                    if (w_srch_rsp.done && (r_cmd == ldm_pkg::CMD_OPEN) &&
                        w_srch_rsp.found) begin
                        r_used[w_fidx]  <= 1'b1;
                        r_bound[w_fidx] <= 1'b0;
                        r_sport[w_fidx] <= 16'd0;
                        r_head[w_fidx]  <= '0;
                        r_tail[w_fidx]  <= '0;
                        r_count[w_fidx] <= '0;
                    end
                    if (w_srch_rsp.done && (r_cmd == ldm_pkg::CMD_BIND) &&
                        !w_srch_rsp.found) begin
                        r_sport[w_hslot] <= r_port;
                        r_bound[w_hslot] <= 1'b1;
                    end
                end
                ldm_pkg::ST_SEND_CHECK: begin
                    if (w_full) begin
                        r_drop <= r_drop + 32'd1;
                    end else begin
                        r_active <= 1'b1;
                    end
                end
                ldm_pkg::ST_SEND_BYTE: begin
                    if (w_commit) begin
                        r_head[r_dst]  <= w_head_inc;
                        r_count[r_dst] <= w_vcount + CW'(1);
                        r_sent         <= r_sent + 32'd1;
                        r_active       <= 1'b0;
                    end
                end
                default: r_active <= r_active;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= s_axis_tuser;
            r_handle <= s_axis_tdata[7:0];
            r_port   <= s_axis_tdata[23:8];
            r_len    <= s_axis_tdata[30:24];
            r_byte   <= s_axis_tdata[38:31];
            r_dom    <= s_axis_tdata[46:39];
            r_kind   <= s_axis_tdata[54:47];
            r_prot   <= s_axis_tdata[62:55];
        end
        case (r_state)
            ldm_pkg::ST_DECODE: begin
                if (!r_active) begin
                    r_slen <= r_len;
                    r_src  <= w_view.port;
                end
                r_ent <= {w_hslot, w_vtail};
                r_cap <= (r_len > MAXP7) ? MAXP7 : r_len;
            end
            ldm_pkg::ST_SEARCH: begin
                if (w_srch_rsp.done) r_dst <= w_fidx;
            end
            ldm_pkg::ST_SEND_CHECK: begin
                r_done <= 7'd0;
                if (!w_full) r_meta_mem[{r_dst, w_vhead}] <= {r_src, r_slen};
            end
            ldm_pkg::ST_SEND_BYTE: begin
                r_pay_mem[{r_dst, w_vhead, r_done[PW-1:0]}] <= r_byte;
                r_done <= 7'(r_done + 7'd1);
            end
            ldm_pkg::ST_RX_META: r_meta_rd <= r_meta_mem[r_ent];
            ldm_pkg::ST_RX_LEN: begin
                r_n <= w_n;
                r_i <= 7'd0;
            end
            ldm_pkg::ST_RX_READ: r_pay_rd <= r_pay_mem[{r_ent, r_i[PW-1:0]}];
            ldm_pkg::ST_RX_EMIT: begin
                if (w_ofree) r_i <= 7'(r_i + 7'd1);
            end
            default: r_i <= r_i;
        endcase
        if ((n_state == ldm_pkg::ST_RESULT) && (r_state != ldm_pkg::ST_RESULT)) begin
            r_res_status <= w_res_status;
            r_res_value  <= w_res_value;
            r_res_src    <= w_res_src;
            r_res_cnt    <= w_res_cnt;
        end else if (r_state == ldm_pkg::ST_RX_LEN) begin
            r_res_src <= w_meta_src;
        end
        if (w_ld_result) begin
            r_o_status <= r_res_status;
            r_o_value  <= r_res_value;
            r_o_byte   <= 8'd0;
            r_o_bv     <= 1'b0;
            r_o_src    <= r_res_src;
            r_o_last   <= 1'b1;
            r_o_sent   <= r_res_cnt ? r_sent : 32'd0;
            r_o_recv   <= r_res_cnt ? r_recv : 32'd0;
            r_o_drop   <= r_res_cnt ? r_drop : 32'd0;
        end else if (w_ld_byte) begin
            r_o_status <= 1'b0;
            r_o_value  <= {1'b0, r_n};
            r_o_byte   <= r_pay_rd;
            r_o_bv     <= 1'b1;
            r_o_src    <= r_res_src;
            r_o_last   <= w_rx_last;
            r_o_sent   <= 32'd0;
            r_o_recv   <= 32'd0;
            r_o_drop   <= 32'd0;
        end
    end

    assign s_axis_tready = (r_state == ldm_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_bv;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {7'd0, r_o_drop, r_o_recv, r_o_sent, r_o_src,
                            r_o_byte, r_o_value, r_o_status};

    `ASSERT_CLK(a_send_progress, i_clk, i_rst_n, r_active |-> (r_done < r_slen), "send count overran length")
    `ASSERT_CLK(a_send_active, i_clk, i_rst_n, (r_state == ldm_pkg::ST_SEND_BYTE) |-> r_active, "payload word without open send")
    `ASSERT_CLK(a_rx_count, i_clk, i_rst_n, (r_state == ldm_pkg::ST_RX_EMIT) |-> (r_i < r_n), "receive word beyond datagram")

endmodule
